// ===== design/euler_to_quaternion_unit_macros.svh =====
// Assertion macros used by the checker file.
`ifndef EULER_TO_QUATERNION_UNIT_MACROS_SVH
`define EULER_TO_QUATERNION_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define E2Q_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("e2q check failed");
// Next-cycle implication checked outside reset.
`define E2Q_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("e2q check failed");
`endif

// ===== design/e2q_pkg.sv =====
// Package: widths, CORDIC constants and helpers for the Euler to quaternion unit.
package e2q_pkg;
   localparam int AngleBits = 16;
   localparam int TrigSteps = 16;
   localparam int QBits     = 16;
   localparam int WBits     = 34;   // Q.30 working width with headroom
   localparam int NStage    = TrigSteps + 5;

   localparam logic signed [WBits-1:0] InvGain = 34'sd652032874;
   localparam logic signed [WBits-1:0] PiQ     = 34'sd3373259426;
   localparam logic signed [WBits-1:0] HalfPiQ = 34'sd1686629713;

   typedef logic signed [WBits-1:0] word_type;

   function automatic word_type atan_entry(input int idx);
      word_type r;
      case (idx)
         0: r = 34'sd843314856;   1: r = 34'sd497837829;
         2: r = 34'sd263043836;   3: r = 34'sd133525158;
         4: r = 34'sd67021686;    5: r = 34'sd33543515;
         6: r = 34'sd16775850;    7: r = 34'sd8388437;
         8: r = 34'sd4194282;     9: r = 34'sd2097149;
         10: r = 34'sd1048575;    11: r = 34'sd524287;
         12: r = 34'sd262143;     13: r = 34'sd131071;
         14: r = 34'sd65535;      15: r = 34'sd32767;
         16: r = 34'sd16383;      17: r = 34'sd8191;
         18: r = 34'sd4095;       19: r = 34'sd2047;
         20: r = 34'sd1023;       21: r = 34'sd511;
         22: r = 34'sd255;        23: r = 34'sd127;
         24: r = 34'sd63;         25: r = 34'sd31;
         26: r = 34'sd15;         27: r = 34'sd7;
         28: r = 34'sd3;          29: r = 34'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Q.30 product rounded back to Q.30.
   function automatic word_type mul_q(input word_type a, input word_type b);
      logic signed [2*WBits-1:0] p;
      p = (2*WBits)'(a) * (2*WBits)'(b) + (2*WBits)'(64'sd536870912);
      return word_type'(p >>> 30);
   endfunction

   // Q.30 to saturated Q1.14.
   function automatic logic signed [QBits-1:0] to_q14(input word_type v);
      word_type r;
      r = (v + word_type'(34'sd32768)) >>> 16;
      if (r > word_type'(34'sd16384))       return 16'sd16384;
      else if (r < -word_type'(34'sd16384)) return -16'sd16384;
      return r[QBits-1:0];
   endfunction
endpackage

// ===== design/euler_to_quaternion_unit.sv =====
// Top level: pipelined Euler angle to quaternion converter.
// Usage:
//  - req_ channel: three signed Q3.13 angles and a 5-bit axis order code,
//    one beat accepted when req_valid is high and req_stall is low.
//  - rsp_ channel: one quaternion (Q1.14, saturated to +-1.0) per request
//    beat, taken when rsp_valid is high and rsp_stall is low.
//  - Pipeline order: decode and range reduction, the CORDIC iterations,
//    the outer and middle lane product stages, a combine stage and the
//    output register.
//  - Throughput: one beat per cycle while rsp_stall is low; the CORDIC
//    stages are unrolled, one register stage per iteration, three lanes in parallel.
//  - Stall: rsp_stall freezes the whole pipeline; req_stall follows it
//    combinationally, so nothing is lost or repeated.
//  - Reset: synchronous active high; clears every stage valid bit, so the
//    output goes idle. Data registers are not reset.
module euler_to_quaternion_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [e2q_pkg::AngleBits-1:0] req_angle_first,
   input  logic signed [e2q_pkg::AngleBits-1:0] req_angle_second,
   input  logic signed [e2q_pkg::AngleBits-1:0] req_angle_third,
   input  logic [4:0]  req_axis_order,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [e2q_pkg::QBits-1:0] rsp_quat_w,
   output logic signed [e2q_pkg::QBits-1:0] rsp_quat_x,
   output logic signed [e2q_pkg::QBits-1:0] rsp_quat_y,
   output logic signed [e2q_pkg::QBits-1:0] rsp_quat_z
);
   localparam int N = e2q_pkg::TrigSteps;

   // Decoded control that rides along the pipe.
   typedef struct packed {
      logic       rep;
      logic       par;
      logic [1:0] ai;
      logic [1:0] aj;
      logic [1:0] ak;
   } ctl_type;

   logic advance;
   assign advance   = !rsp_stall;
   assign req_stall = rsp_stall;

   // CORDIC lane registers, index 0 = after range reduction.
   e2q_pkg::word_type x_ff [0:N][0:2];
   e2q_pkg::word_type y_ff [0:N][0:2];
   e2q_pkg::word_type z_ff [0:N][0:2];
   logic    flip_ff [0:N][0:2];
   ctl_type ctl_ff  [0:N];
   logic    v_ff    [0:N];

   // Decode and scale.
   ctl_type ctl_in;
   e2q_pkg::word_type t_in [0:2];
   always_comb begin
      logic [1:0] fi;
      e2q_pkg::word_type a0, a1, a2;
      fi = (req_axis_order[4:3] == 2'd3) ? 2'd0 : req_axis_order[4:3];
      ctl_in.rep = req_axis_order[1];
      ctl_in.par = req_axis_order[2];
      ctl_in.ai  = fi;
      ctl_in.aj  = req_axis_order[2] ? ((fi == 2'd0) ? 2'd2 : fi - 2'd1)
                                     : ((fi == 2'd2) ? 2'd0 : fi + 2'd1);
      ctl_in.ak  = req_axis_order[2] ? ((fi == 2'd2) ? 2'd0 : fi + 2'd1)
                                     : ((fi == 2'd0) ? 2'd2 : fi - 2'd1);
      a0 = e2q_pkg::word_type'(req_angle_first)  <<< (32 - e2q_pkg::AngleBits);
      a1 = e2q_pkg::word_type'(req_angle_second) <<< (32 - e2q_pkg::AngleBits);
      a2 = e2q_pkg::word_type'(req_angle_third)  <<< (32 - e2q_pkg::AngleBits);
      t_in[0] = req_axis_order[0] ? a2 : a0;
      t_in[1] = req_axis_order[2] ? -a1 : a1;
      t_in[2] = req_axis_order[0] ? a0 : a2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= N; s++) v_ff[s] <= 1'b0;
      end else if (advance) begin
         v_ff[0] <= req_valid;
         for (int s = 1; s <= N; s++) v_ff[s] <= v_ff[s-1];
      end
   end

   // Stage 0: range reduction.
   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= ctl_in;
         for (int l = 0; l < 3; l++) begin
            x_ff[0][l] <= e2q_pkg::InvGain;
            y_ff[0][l] <= '0;
            if (t_in[l] > e2q_pkg::HalfPiQ) begin
               z_ff[0][l] <= t_in[l] - e2q_pkg::PiQ;  flip_ff[0][l] <= 1'b1;
            end else if (t_in[l] < -e2q_pkg::HalfPiQ) begin
               z_ff[0][l] <= t_in[l] + e2q_pkg::PiQ;  flip_ff[0][l] <= 1'b1;
            end else begin
               z_ff[0][l] <= t_in[l];                 flip_ff[0][l] <= 1'b0;
            end
         end
      end
   end

   // One CORDIC iteration per stage.
   for (genvar s = 0; s < N; s++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (advance) begin
            ctl_ff[s+1] <= ctl_ff[s];
            for (int l = 0; l < 3; l++) begin
               flip_ff[s+1][l] <= flip_ff[s][l];
               if (!z_ff[s][l][e2q_pkg::WBits-1]) begin
                  x_ff[s+1][l] <= x_ff[s][l] - (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] + (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] - e2q_pkg::atan_entry(s);
               end else begin
                  x_ff[s+1][l] <= x_ff[s][l] + (y_ff[s][l] >>> s);
                  y_ff[s+1][l] <= y_ff[s][l] - (x_ff[s][l] >>> s);
                  z_ff[s+1][l] <= z_ff[s][l] + e2q_pkg::atan_entry(s);
               end
            end
         end
      end
   end

   // Sines and cosines with the flip applied.
   e2q_pkg::word_type cs_c [0:2];
   e2q_pkg::word_type sn_c [0:2];
   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cs_c[l] = flip_ff[N][l] ? -x_ff[N][l] : x_ff[N][l];
         sn_c[l] = flip_ff[N][l] ? -y_ff[N][l] : y_ff[N][l];
      end
   end

   // Product stage 1: outer lane products.
   e2q_pkg::word_type cc_ff, cs_ff, sc_ff, ss_ff, cj_ff, sj_ff;
   ctl_type ctl1_ff, ctl2_ff;
   logic    v1_ff, v2_ff, v3_ff, v4_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         cc_ff <= e2q_pkg::mul_q(cs_c[0], cs_c[2]);
         cs_ff <= e2q_pkg::mul_q(cs_c[0], sn_c[2]);
         sc_ff <= e2q_pkg::mul_q(sn_c[0], cs_c[2]);
         ss_ff <= e2q_pkg::mul_q(sn_c[0], sn_c[2]);
         cj_ff <= cs_c[1];
         sj_ff <= sn_c[1];
         ctl1_ff <= ctl_ff[N];
      end
   end

   // Product stage 2: middle lane products.
   e2q_pkg::word_type p_ff [0:7];
   always_ff @(posedge clock) begin
      if (advance) begin
         ctl2_ff <= ctl1_ff;
         if (ctl1_ff.rep) begin
            p_ff[0] <= e2q_pkg::mul_q(cj_ff, cs_ff + sc_ff);
            p_ff[1] <= e2q_pkg::mul_q(sj_ff, cc_ff + ss_ff);
            p_ff[2] <= e2q_pkg::mul_q(sj_ff, cs_ff - sc_ff);
            p_ff[3] <= e2q_pkg::mul_q(cj_ff, cc_ff - ss_ff);
            for (int q = 4; q < 8; q++) p_ff[q] <= '0;
         end else begin
            p_ff[0] <= e2q_pkg::mul_q(cj_ff, sc_ff);
            p_ff[4] <= e2q_pkg::mul_q(sj_ff, cs_ff);
            p_ff[1] <= e2q_pkg::mul_q(cj_ff, ss_ff);
            p_ff[5] <= -e2q_pkg::mul_q(sj_ff, cc_ff);
            p_ff[2] <= e2q_pkg::mul_q(cj_ff, cs_ff);
            p_ff[6] <= e2q_pkg::mul_q(sj_ff, sc_ff);
            p_ff[3] <= e2q_pkg::mul_q(cj_ff, cc_ff);
            p_ff[7] <= -e2q_pkg::mul_q(sj_ff, ss_ff);
         end
      end
   end

   // Combine, place into axes and round.
   e2q_pkg::word_type a_c [0:2];
   logic signed [e2q_pkg::QBits-1:0] qw_in, qx_in, qy_in, qz_in;
   always_comb begin
      e2q_pkg::word_type vi, vj, vk;
      vi = p_ff[0] - p_ff[4];
      vj = p_ff[1] - p_ff[5];
      vk = p_ff[2] - p_ff[6];
      if (ctl2_ff.par) vj = -vj;
      for (int l = 0; l < 3; l++) a_c[l] = '0;
      a_c[ctl2_ff.ai] = vi;
      a_c[ctl2_ff.aj] = vj;
      a_c[ctl2_ff.ak] = vk;
      qw_in = e2q_pkg::to_q14(p_ff[3] - p_ff[7]);
      qx_in = e2q_pkg::to_q14(a_c[0]);
      qy_in = e2q_pkg::to_q14(a_c[1]);
      qz_in = e2q_pkg::to_q14(a_c[2]);
   end

   logic signed [e2q_pkg::QBits-1:0] qw_ff, qx_ff, qy_ff, qz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         qw_ff <= qw_in;  qx_ff <= qx_in;  qy_ff <= qy_in;  qz_ff <= qz_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;  v2_ff <= 1'b0;  v3_ff <= 1'b0;  v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= v_ff[N];  v2_ff <= v1_ff;  v3_ff <= v2_ff;  v4_ff <= v3_ff;
      end
   end

   // Output stage.
   logic signed [e2q_pkg::QBits-1:0] ow_ff, ox_ff, oy_ff, oz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         ow_ff <= qw_ff;  ox_ff <= qx_ff;  oy_ff <= qy_ff;  oz_ff <= qz_ff;
      end
   end

   assign rsp_valid  = v4_ff;
   assign rsp_quat_w = ow_ff;
   assign rsp_quat_x = ox_ff;
   assign rsp_quat_y = oy_ff;
   assign rsp_quat_z = oz_ff;
endmodule

// ===== design/e2q_checker.sv =====
// Checker: port-level assertions for the Euler to quaternion unit.
`include "euler_to_quaternion_unit_macros.svh"
module e2q_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic signed [15:0] rsp_quat_w,
   input logic signed [15:0] rsp_quat_x
);
   localparam logic signed [15:0] One = 16'sd16384;

   `E2Q_ASSERT_IMP(a_w_range, clock, reset, rsp_valid, rsp_quat_w <= One && rsp_quat_w >= -One)
   `E2Q_ASSERT_IMP(a_x_range, clock, reset, rsp_valid, rsp_quat_x <= One && rsp_quat_x >= -One)
   `E2Q_ASSERT_IMP(a_stall_pass, clock, reset, 1'b1, req_stall == rsp_stall)
   `E2Q_ASSERT_NXT(a_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_quat_w))
endmodule

bind euler_to_quaternion_unit e2q_checker u_e2q_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x)
);

// ===== tb/sv/testbench.sv =====
// Testbench for euler_to_quaternion_unit: random and directed angles against a bit-true predictor.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] w;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } quat_type;

   // Truncated arctangent table in Q.30, one entry per CORDIC step.
   localparam longint ArcTab [16] = '{
      843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149,
      1048575, 524287, 262143, 131071, 65535, 32767};
   localparam longint GainInv = 652032874;
   localparam longint PiFix = 64'd3373259426;
   localparam longint HalfPiFix = 1686629713;
   localparam int WatchLimit = 5000;
   localparam int TailCycles = 40;

   // Keeps the quaternions still owed by the block and grades each one that comes out.
   class quat_ledger_type;
      quat_type owed[$];
      int mismatches = 0;
      int graded = 0;

      static function longint fix_mul(longint a, longint b);
         return (a * b + (64'sd1 <<< 29)) >>> 30;
      endfunction

      static function logic [15:0] to_comp(longint v);
         longint r;
         r = (v + 32768) >>> 16;
         if (r > 16384) r = 16384;
         if (r < -16384) r = -16384;
         return r[15:0];
      endfunction

      static function void half_sincos(input longint ang, output longint c,
                                       output longint s);
         longint xr, yr, zr, dx, dy;
         bit flip;
         xr = GainInv;
         yr = 0;
         zr = ang;
         flip = 0;
         if (zr > HalfPiFix) begin
            zr -= PiFix;
            flip = 1;
         end else if (zr < -HalfPiFix) begin
            zr += PiFix;
            flip = 1;
         end
         for (int n = 0; n < 16; n++) begin
            dx = yr >>> n;
            dy = xr >>> n;
            if (zr >= 0) begin
               xr -= dx; yr += dy; zr -= ArcTab[n];
            end else begin
               xr += dx; yr -= dy; zr += ArcTab[n];
            end
         end
         c = flip ? -xr : xr;
         s = flip ? -yr : yr;
      endfunction

      static function quat_type rotate_to_quat(logic [15:0] a0, logic [15:0] a1,
                                               logic [15:0] a2, logic [4:0] ord);
         int nxt [4] = '{1, 2, 0, 1};
         int ia, ja, ka;
         bit par, rep;
         longint t0, t1, t2, tmp, ci, si, cj, sj, ch, sh, cc, cs, sc, ss, w;
         longint v [3];
         quat_type q;
         par = ord[2];
         rep = ord[1];
         ia = (ord[4:3] == 2'd3) ? 0 : int'(ord[4:3]);
         ja = nxt[ia + int'(par)];
         ka = nxt[ia + 1 - int'(par)];
         t0 = longint'($signed(a0)) * 65536;
         t1 = longint'($signed(a1)) * 65536;
         t2 = longint'($signed(a2)) * 65536;
         if (ord[0]) begin
            tmp = t0; t0 = t2; t2 = tmp;
         end
         if (par) t1 = -t1;
         half_sincos(t0, ci, si);
         half_sincos(t1, cj, sj);
         half_sincos(t2, ch, sh);
         cc = fix_mul(ci, ch); cs = fix_mul(ci, sh);
         sc = fix_mul(si, ch); ss = fix_mul(si, sh);
         if (rep) begin
            v[ia] = fix_mul(cj, cs + sc);
            v[ja] = fix_mul(sj, cc + ss);
            v[ka] = fix_mul(sj, cs - sc);
            w = fix_mul(cj, cc - ss);
         end else begin
            v[ia] = fix_mul(cj, sc) - fix_mul(sj, cs);
            v[ja] = fix_mul(cj, ss) + fix_mul(sj, cc);
            v[ka] = fix_mul(cj, cs) - fix_mul(sj, sc);
            w = fix_mul(cj, cc) + fix_mul(sj, ss);
         end
         if (par) v[ja] = -v[ja];
         q.w = to_comp(w);
         q.x = to_comp(v[0]);
         q.y = to_comp(v[1]);
         q.z = to_comp(v[2]);
         return q;
      endfunction

      function void note_angles(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                logic [4:0] ord);
         owed.push_back(rotate_to_quat(a0, a1, a2, ord));
      endfunction

      function void grade_quat(quat_type got);
         quat_type want;
         graded++;
         if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected quaternion w=%h x=%h y=%h z=%h",
                        got.w, got.x, got.y, got.z);
            return;
         end
         want = owed.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("quaternion mismatch: want w=%h x=%h y=%h z=%h, got w=%h x=%h y=%h z=%h",
                        want.w, want.x, want.y, want.z, got.w, got.x, got.y, got.z);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_angle_first = '0;
   logic signed [15:0] req_angle_second = '0;
   logic signed [15:0] req_angle_third = '0;
   logic [4:0] req_axis_order = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   quat_ledger_type ledger = new();
   int beats_in = 0;
   int quiet_cycles = 0;
   bit calm = 0;        // no idling on either side while set
   bit hold_rsp = 0;    // ask the receiver for one long hold-off
   bit failed = 0;

   euler_to_quaternion_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_angle_first(req_angle_first), .req_angle_second(req_angle_second),
      .req_angle_third(req_angle_third), .req_axis_order(req_axis_order),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z));

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one beat and hold it until the block takes it.
   task automatic send_angles(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                              logic [4:0] ord);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle_first <= a0;
      req_angle_second <= a1;
      req_angle_third <= a2;
      req_axis_order <= ord;
      do @(posedge clock); while (req_stall);
      ledger.note_angles(a0, a1, a2, ord);
      beats_in++;
   endtask

   // Mostly in-range angles, sometimes any 16-bit pattern to hit the range fold.
   function automatic logic [15:0] pick_angle();
      if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 51472)) - 25736);
      return 16'($urandom());
   endfunction

   // Receiver: check every taken beat, then choose the next stall level.
   always @(posedge clock) begin
      static int stall_left = 0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            ledger.grade_quat({rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z});
         end
         if (hold_rsp) begin
            hold_rsp = 0;
            stall_left = 150;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (calm || $urandom_range(0, 99) < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2)
                                                   : $urandom_range(10, 50);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Watchdog: count cycles in which neither side moves a beat.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("watchdog expired with %0d quaternions owed", ledger.owed.size());
         $display("euler_to_quaternion_unit verification failed");
         $finish;
      end
   end

   initial begin
      static logic [15:0] edges [6] = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd32767,
                                        16'sh8000, 16'sd12868};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: order codes 0 to 23 and 31 once each, angles cycling through the extremes.
      for (int n = 0; n < 24; n++)
         send_angles(edges[n % 6], edges[(n + 2) % 6], edges[(n + 4) % 6], 5'(n));
      send_angles(16'sd25736, -16'sd25736, 16'sd12868, 5'd31);

      for (int n = 0; n < 850; n++) begin
         calm = ((n / 100) % 3 == 1);
         if (n == 300) hold_rsp = 1;   // block fills while we keep offering
         if (n == 600) begin
            req_valid <= 1'b0;
            while (ledger.owed.size() > 0) @(posedge clock);
         end
         send_angles(pick_angle(), pick_angle(), pick_angle(), 5'($urandom_range(0, 31)));
      end
      req_valid <= 1'b0;

      while (ledger.owed.size() > 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      failed = (ledger.mismatches > 0);
      $display("sent %0d angle triples over all 32 order codes, graded %0d quaternions",
               beats_in, ledger.graded);
      $display("mismatches: %0d, including long output hold-off and drain pause",
               ledger.mismatches);
      if (!failed) begin
         $display("euler_to_quaternion_unit verification clean");
      end else begin
         $display("euler_to_quaternion_unit verification failed");
      end
      $finish;
   end
endmodule
